// ----- src/tad_pkg.sv -----
package tad_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int DS_W = 8;
  localparam logic [DS_W-1:0] DS_RESET = 8'd50;
  localparam int DEG_W = 8;
  localparam int COS_IDX_W = 7;
  localparam logic [DEG_W-1:0] MAX_DEG = 8'd180;
  localparam logic [DEG_W-1:0] RIGHT_DEG = 8'd90;
  localparam logic [1:0] DCNT_ONE = 2'd1;
  localparam logic [1:0] DCNT_TWO = 2'd2;
  localparam logic [1:0] DCNT_THREE = 2'd3;

  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] DEG_Q60 = PI_Q60 / 180;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } tad_in_t;

  typedef struct packed {
    logic [7:0] tilt_degrees;
    logic [3:0] digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_ones;
    logic [1:0] digit_count;
    logic       invalid;
  } tad_out_t;

  typedef logic [63:0] cos_tab_t [0:90];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] div_long(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic cos_tab_t build_cos_sq();
    cos_tab_t tab;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] dv;
    for (int k = 0; k <= 90; k++) begin
      theta = 64'(k) * DEG_Q60;
      t2 = mul_q60(theta, theta);
      term = ONE_Q60;
      sum = ONE_Q60;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          dv = 64'((2 * n - 1) * (2 * n));
          term = div_long(mul_q60(term, t2), dv);
          if ((n % 2) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[k] = mul_q60(sum, sum);
    end
    tab[0] = ONE_Q60;
    tab[30] = 64'h3 << 58;
    tab[45] = 64'h1 << 59;
    tab[60] = 64'h1 << 58;
    tab[90] = 64'd0;
    return tab;
  endfunction

  localparam cos_tab_t COS_SQ = build_cos_sq();

endpackage

// ----- src/tad_div.sv -----
module tad_div #(
  parameter int SB = tad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  tad_pkg::tad_in_t          in_data,
  input  logic [tad_pkg::DS_W-1:0]  downscale,
  output logic                      out_v,
  output logic [SB-1:0]             mag_x,
  output logic [SB-1:0]             mag_y,
  output logic [SB-1:0]             mag_z,
  output logic                      y_neg
);
  import tad_pkg::*;

  localparam int STEPS = 4;
  localparam int NST = (SB + STEPS - 1) / STEPS;

  typedef struct packed {
    logic [SB-1:0]   q;
    logic [DS_W-1:0] rem;
  } ax_t;

  typedef struct packed {
    ax_t [2:0]       ax;
    logic [DS_W-1:0] d;
    logic            yn;
  } dv_t;

  logic [NST:0] v_r;
  dv_t          st_r   [0:NST];
  dv_t          st_nxt [0:NST];

  always_comb begin
    logic [SB-1:0] raw [0:2];
    raw[0] = in_data.accel_x[SB-1:0];
    raw[1] = in_data.accel_y[SB-1:0];
    raw[2] = in_data.accel_z[SB-1:0];
    for (int a = 0; a < 3; a++) begin
      st_nxt[0].ax[a].q = raw[a][SB-1] ? (~raw[a] + 1'b1) : raw[a];
      st_nxt[0].ax[a].rem = '0;
    end
    st_nxt[0].d = (downscale == '0) ? DS_W'(1) : downscale;
    st_nxt[0].yn = raw[1][SB-1];
  end

  for (genvar i = 0; i < NST; i++) begin : g_stage
    always_comb begin
      dv_t w;
      logic [DS_W:0] t;
      w = st_r[i];
      for (int j = 0; j < STEPS; j++) begin
        if (i * STEPS + j < SB) begin
          for (int a = 0; a < 3; a++) begin
            t = {w.ax[a].rem, w.ax[a].q[SB-1]};
            w.ax[a].q = w.ax[a].q << 1;
            if (t >= {1'b0, w.d}) begin
              t = t - {1'b0, w.d};
              w.ax[a].q[0] = 1'b1;
            end
            w.ax[a].rem = t[DS_W-1:0];
          end
        end
      end
      st_nxt[i+1] = w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_v = v_r[NST];
  assign mag_x = st_r[NST].ax[0].q;
  assign mag_y = st_r[NST].ax[1].q;
  assign mag_z = st_r[NST].ax[2].q;
  assign y_neg = st_r[NST].yn;

endmodule

// ----- src/tad_search.sv -----
module tad_search #(
  parameter int SB = tad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [SB-1:0]              mag_x,
  input  logic [SB-1:0]              mag_y,
  input  logic [SB-1:0]              mag_z,
  input  logic                       y_neg,
  output logic                       out_v,
  output logic [tad_pkg::DEG_W-1:0]  out_deg,
  output logic                       out_inv
);
  import tad_pkg::*;

  localparam int SQ_W = 2 * SB;
  localparam int S_W = 2 * SB + 2;
  localparam int PH_W = 32 + S_W;
  localparam int P_W = 64 + S_W;

  typedef struct packed {
    logic [S_W-1:0]   s;
    logic [SQ_W-1:0]  ysq;
    logic             ypos;
    logic             yneg;
    logic             inv;
    logic [DEG_W-1:0] lo;
  } srch_t;

  typedef struct packed {
    srch_t            b;
    logic [PH_W-1:0]  ph;
    logic [PH_W-1:0]  pl;
    logic [DEG_W-1:0] cand;
    logic             rng;
  } mul_t;

  logic            sq_v_r;
  logic [SQ_W-1:0] xs_r, ys_r, zs_r;
  logic            ypos_r, yneg_r;

  logic [DEG_W:0]  av_r;
  srch_t           a_r   [0:DEG_W];
  srch_t           a_nxt [0:DEG_W];
  logic [DEG_W-1:0] mv_r;
  mul_t            m_r   [0:DEG_W-1];
  mul_t            m_nxt [0:DEG_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r <= SQ_W'(mag_x) * SQ_W'(mag_x);
      ys_r <= SQ_W'(mag_y) * SQ_W'(mag_y);
      zs_r <= SQ_W'(mag_z) * SQ_W'(mag_z);
      ypos_r <= !y_neg && (mag_y != '0);
      yneg_r <= y_neg && (mag_y != '0);
    end
  end

  always_comb begin
    a_nxt[0].s = S_W'(xs_r) + S_W'(ys_r) + S_W'(zs_r);
    a_nxt[0].ysq = ys_r;
    a_nxt[0].ypos = ypos_r;
    a_nxt[0].yneg = yneg_r;
    a_nxt[0].inv = (xs_r == '0) && (ys_r == '0) && (zs_r == '0);
    a_nxt[0].lo = '0;
  end

  for (genvar j = 0; j < DEG_W; j++) begin : g_step
    always_comb begin
      logic [DEG_W-1:0]     cand;
      logic [COS_IDX_W-1:0] ci;
      logic [63:0]          c;
      logic [DEG_W-1:0]     mirror;
      cand = a_r[j].lo + (DEG_W'(1) << (DEG_W - 1 - j));
      mirror = MAX_DEG - cand;
      if (cand <= RIGHT_DEG) begin
        ci = cand[COS_IDX_W-1:0];
      end else if (cand <= MAX_DEG) begin
        ci = mirror[COS_IDX_W-1:0];
      end else begin
        ci = '0;
      end
      c = COS_SQ[ci];
      m_nxt[j].b = a_r[j];
      m_nxt[j].ph = PH_W'(c[63:32]) * PH_W'(a_r[j].s);
      m_nxt[j].pl = PH_W'(c[31:0]) * PH_W'(a_r[j].s);
      m_nxt[j].cand = cand;
      m_nxt[j].rng = (cand <= MAX_DEG);
    end

    always_comb begin
      logic [P_W-1:0] prod;
      logic [P_W-1:0] yw;
      logic           pred;
      prod = {m_r[j].ph, 32'd0} + P_W'(m_r[j].pl);
      yw = P_W'({m_r[j].b.ysq, 60'd0});
      if (m_r[j].cand < RIGHT_DEG) begin
        pred = !m_r[j].b.ypos || (yw <= prod);
      end else if (m_r[j].cand == RIGHT_DEG) begin
        pred = !m_r[j].b.ypos;
      end else begin
        pred = m_r[j].b.yneg && (prod <= yw);
      end
      a_nxt[j+1] = m_r[j].b;
      if (m_r[j].rng && !m_r[j].b.inv && pred) begin
        a_nxt[j+1].lo = m_r[j].cand;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r[j] <= 1'b0;
        av_r[j+1] <= 1'b0;
      end else if (en) begin
        mv_r[j] <= av_r[j];
        av_r[j+1] <= mv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j] <= m_nxt[j];
        a_r[j+1] <= a_nxt[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r[0] <= 1'b0;
    end else if (en) begin
      av_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= a_nxt[0];
    end
  end

  assign out_v = av_r[DEG_W];
  assign out_deg = a_r[DEG_W].lo;
  assign out_inv = a_r[DEG_W].inv;

endmodule

// ----- src/tilt_angle_to_degree_digits.sv -----
// Channel  Ports                                Word
// input    in_valid / in_ready / in_data        tad_in_t (x, y, z sample)
// output   out_valid / out_ready / out_data     tad_out_t (angle, digits, flags)
// config   cfg_we / cfg_data                    downscale, reset value 50
//
// One word enters per cycle while in_ready is high; each word goes through the divide
// stages and then the eight two-stage angle search steps.
// Reset is synchronous and active low; it clears all valid bits and sets downscale to 50.
// A stalled output word is held while one more word lands in a skid register; input
// ready then drops until the skid register drains.
module tilt_angle_to_degree_digits #(
  parameter int SAMPLE_BITS = tad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tad_pkg::tad_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tad_pkg::tad_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [tad_pkg::DS_W-1:0]  cfg_data
);
  import tad_pkg::*;

  logic [DS_W-1:0]  ds_r;
  logic             en;
  logic             dv_v;
  logic [SAMPLE_BITS-1:0] mx, my, mz;
  logic             yn;
  logic             pipe_v;
  logic [DEG_W-1:0] deg;
  logic             inv;
  tad_out_t         res;
  logic             out_v_r, out_v_nxt;
  tad_out_t         out_r, out_nxt;
  logic             skid_v_r, skid_v_nxt;
  tad_out_t         skid_r, skid_nxt;

  assign en = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r <= DS_RESET;
    end else if (cfg_we) begin
      ds_r <= cfg_data;
    end
  end

  tad_div #(.SB(SAMPLE_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (in_valid),
    .in_data   (in_data),
    .downscale (ds_r),
    .out_v     (dv_v),
    .mag_x     (mx),
    .mag_y     (my),
    .mag_z     (mz),
    .y_neg     (yn)
  );

  tad_search #(.SB(SAMPLE_BITS)) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (dv_v),
    .mag_x   (mx),
    .mag_y   (my),
    .mag_z   (mz),
    .y_neg   (yn),
    .out_v   (pipe_v),
    .out_deg (deg),
    .out_inv (inv)
  );

  always_comb begin
    logic [6:0]  r;
    logic [14:0] t;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic        h;
    h = (deg >= 8'd100);
    r = h ? 7'(deg - 8'd100) : deg[6:0];
    t = 15'(r) * 15'd205;
    tens = t[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    res.tilt_degrees = deg;
    res.digit_hundreds = {3'd0, h};
    res.digit_tens = tens;
    res.digit_ones = 4'(r - tens_x10);
    res.digit_count = h ? DCNT_THREE : ((deg >= 8'd10) ? DCNT_TWO : DCNT_ONE);
    res.invalid = inv;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt = skid_r;
    if (skid_v_r) begin
      if (out_ready) begin
        out_nxt = skid_r;
        out_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (out_ready || !out_v_r) begin
      out_v_nxt = pipe_v;
      if (pipe_v) begin
        out_nxt = res;
      end
    end else if (pipe_v) begin
      skid_v_nxt = 1'b1;
      skid_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;

endmodule

// ----- src/tad_checker.sv -----
module tad_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input tad_pkg::tad_out_t         out_data
);
  import tad_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (12'(out_data.digit_hundreds) * 12'd100 + 12'(out_data.digit_tens) * 12'd10
                   + 12'(out_data.digit_ones)) == 12'(out_data.tilt_degrees)
                  && out_data.tilt_degrees <= MAX_DEG)
    else $error("digits do not match the angle");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.digit_count == ((out_data.tilt_degrees >= 8'd100) ? DCNT_THREE :
                  ((out_data.tilt_degrees >= 8'd10) ? DCNT_TWO : DCNT_ONE)))
    else $error("digit count does not match the angle");

  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.tilt_degrees == '0)
    else $error("invalid word carries a nonzero angle");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input ready dropped without an output stall");

endmodule

bind tilt_angle_to_degree_digits tad_checker u_chk (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

import tad_pkg::*;

class tilt_scoreboard;
  tad_out_t angle_q[$];
  logic [DS_W-1:0] downscale;
  int errors;
  int words_checked;

  function new();
    downscale = DS_RESET;
    errors = 0;
    words_checked = 0;
  endfunction

  function automatic bit within_angle(int k, int y, longint unsigned ysq,
                                      longint unsigned mag_sq);
    logic [127:0] y_wide;
    logic [127:0] c_wide;
    y_wide = 128'(ysq) << 60;
    if (k == 90) begin
      return y <= 0;
    end
    if (k < 90) begin
      if (y <= 0) begin
        return 1'b1;
      end
      c_wide = 128'(COS_SQ[k]) * 128'(mag_sq);
      return y_wide <= c_wide;
    end
    if (y >= 0) begin
      return 1'b0;
    end
    c_wide = 128'(COS_SQ[180 - k]) * 128'(mag_sq);
    return c_wide <= y_wide;
  endfunction

  function void note_sample(tad_in_t w);
    int div;
    int x;
    int y;
    int z;
    longint unsigned ysq;
    longint unsigned mag_sq;
    int deg;
    tad_out_t r;
    div = (downscale == 0) ? 1 : int'(downscale);
    x = int'(w.accel_x) / div;
    y = int'(w.accel_y) / div;
    z = int'(w.accel_z) / div;
    ysq = longint'(y) * longint'(y);
    mag_sq = longint'(x) * longint'(x) + ysq + longint'(z) * longint'(z);
    deg = 0;
    if (mag_sq != 0) begin
      for (int k = 1; k <= 180; k++) begin
        if (!within_angle(k, y, ysq, mag_sq)) begin
          break;
        end
        deg = k;
      end
    end
    r.tilt_degrees = 8'(deg);
    r.digit_hundreds = 4'(deg / 100);
    r.digit_tens = 4'((deg / 10) % 10);
    r.digit_ones = 4'(deg % 10);
    r.digit_count = (deg >= 100) ? DCNT_THREE : ((deg >= 10) ? DCNT_TWO : DCNT_ONE);
    r.invalid = (mag_sq == 0);
    angle_q.push_back(r);
  endfunction

  function void check_result(tad_out_t got);
    tad_out_t exp_w;
    if (angle_q.size() == 0) begin
      $error("Result word with no expectation pending: %h", got);
      errors++;
      return;
    end
    exp_w = angle_q.pop_front();
    words_checked++;
    if (got.tilt_degrees !== exp_w.tilt_degrees) begin
      $error("tilt_degrees expected %0d actual %0d", exp_w.tilt_degrees, got.tilt_degrees);
      errors++;
    end
    if (got.digit_hundreds !== exp_w.digit_hundreds) begin
      $error("digit_hundreds expected %0d actual %0d", exp_w.digit_hundreds,
             got.digit_hundreds);
      errors++;
    end
    if (got.digit_tens !== exp_w.digit_tens) begin
      $error("digit_tens expected %0d actual %0d", exp_w.digit_tens, got.digit_tens);
      errors++;
    end
    if (got.digit_ones !== exp_w.digit_ones) begin
      $error("digit_ones expected %0d actual %0d", exp_w.digit_ones, got.digit_ones);
      errors++;
    end
    if (got.digit_count !== exp_w.digit_count) begin
      $error("digit_count expected %0d actual %0d", exp_w.digit_count, got.digit_count);
      errors++;
    end
    if (got.invalid !== exp_w.invalid) begin
      $error("invalid expected %0d actual %0d", exp_w.invalid, got.invalid);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tad_in_t in_data;
  logic out_valid;
  logic out_ready;
  tad_out_t out_data;
  logic cfg_we;
  logic [DS_W-1:0] cfg_data;

  tilt_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int words_sent;

  tilt_angle_to_degree_digits dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.accel_x = x;
    in_data.accel_y = y;
    in_data.accel_z = z;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_sample(in_data);
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_downscale(logic [DS_W-1:0] v);
    while (sb.angle_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.downscale = v;
  endtask

  task automatic send_random_sample();
    int a;
    int kind;
    kind = $urandom_range(9);
    a = $urandom_range(32767);
    case (kind)
      0: begin
        send_sample(16'(a), 16'(a), 16'(0));
      end
      1: begin
        send_sample(16'(0), 16'(-a), 16'(a));
      end
      2: begin
        send_sample(16'(0), 16'($urandom_range(65535)), 16'(0));
      end
      3: begin
        send_sample(16'($urandom_range(600) - 300), 16'($urandom_range(600) - 300),
                    16'($urandom_range(600) - 300));
      end
      4: begin
        send_sample(16'($urandom_range(65535)), 16'(0), 16'($urandom_range(65535)));
      end
      default: begin
        send_sample(16'($urandom), 16'($urandom), 16'($urandom));
      end
    endcase
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    out_ready = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycles = 0;
    words_sent = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset value of the divisor first, then an undivided pass for exact angles.
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'd49, 16'hFFCF, 16'd0);
    write_downscale(8'd1);
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd1, 16'd0);
    send_sample(16'd0, 16'hFFFF, 16'd0);
    send_sample(16'd1, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'hFFFF);
    send_sample(16'd1000, 16'd1000, 16'd0);
    send_sample(16'd0, 16'hFC18, 16'd1000);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'd12, 16'd100, 16'd0);
    send_sample(16'd100, 16'd5, 16'd0);
    send_sample(16'd3, 16'hFF9C, 16'd4);
    write_downscale(8'd0);
    send_sample(16'd0, 16'd7, 16'd0);
    send_sample(16'h8000, 16'h0000, 16'h7FFF);
    write_downscale(8'd255);
    send_sample(16'd254, 16'hFF02, 16'd254);
    send_sample(16'd255, 16'd0, 16'd0);
    send_sample(16'h8000, 16'h7FFF, 16'd0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      case (phase)
        0: write_downscale(8'd1);
        1: write_downscale(8'd50);
        2: write_downscale(8'd255);
        3: write_downscale(8'd0);
        default: write_downscale(8'($urandom_range(255)));
      endcase
      repeat (66) send_random_sample();
    end

    send_idle_pct = 0;
    while (sb.angle_q.size() != 0) begin
      @(negedge clk);
    end
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d samples across eight divisor settings and four flow-control mixes,",
             words_sent);
    $display("checked %0d result words with %0d mismatches.", sb.words_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/tad_pkg.sv
src/tad_div.sv
src/tad_search.sv
src/tilt_angle_to_degree_digits.sv
src/tad_checker.sv
dv/testbench.sv
